// ----- rtl/csdd_pkg.sv -----
package csdd_pkg;

	localparam int BUDGET_BITS_DEF = 20;
	localparam int REGION_BITS     = 20;
	localparam int COUNT_BITS      = 32;
	localparam int NEED_BITS       = COUNT_BITS + 4;

	localparam logic [4:0] CODE_END     = 5'd0;
	localparam logic [4:0] CODE_RAW     = 5'd1;
	localparam logic [4:0] CODE_MFM     = 5'd2;
	localparam logic [4:0] CODE_MFM_ALT = 5'd3;
	localparam logic [4:0] CODE_WEAK    = 5'd5;

	localparam logic [4:0] CELLS_RAW = 5'd8;
	localparam logic [4:0] CELLS_MFM = 5'd16;

	typedef enum logic [2:0] {
		K_RAW  = 3'd0,
		K_MFM  = 3'd1,
		K_WEAK = 3'd2,
		K_OK   = 3'd3,
		K_ERR  = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		PH_CMD     = 2'd0,
		PH_COUNT   = 2'd1,
		PH_PAYLOAD = 2'd2,
		PH_DONE    = 2'd3
	} phase_t;

	typedef struct packed {
		logic [7:0] desc_byte;
		logic       end_of_buffer;
		logic       start_of_block;
	} in_item_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] cells;
		logic [4:0]  cell_count;
		logic [19:0] weak_cells;
		logic        has_weak;
		logic        last;
	} out_item_t;

	function automatic logic [15:0] mfm_byte(input logic [7:0] b, input logic ctx);
		logic [15:0] r;
		logic        prev;
		r = '0;
		prev = ctx;
		for (int i = 7; i >= 0; i--) begin
			r = {r[13:0], (~prev & ~b[i]), b[i]};
			prev = b[i];
		end
		return r;
	endfunction

endpackage

// ----- rtl/cell_stream_description_decoder.sv -----
// Channel  Direction  Handshake             Payload
// in       input      in_valid / in_stall   in_item_t: desc_byte, end_of_buffer, start_of_block
// out      output     out_valid / out_stall out_item_t: kind, cells, cell_count, weak_cells, ...
// cfg      input      cfg_valid / cfg_ready cfg_data: region_cells
//
// One byte per cycle unless a result is stalled: a byte enters the input register, is
// decoded against the parser state in one pass, and the output register takes its result.
// Bytes that give no result retire even while the output register is stalled.
// arst_n clears the parser state, the budget register and both valid bits.
// cfg_ready is always high; region_cells takes effect on the next start_of_block.
module cell_stream_description_decoder
	import csdd_pkg::*;
#(
	parameter int BUDGET_BITS = BUDGET_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  in_item_t               in_data,
	output logic                   out_valid,
	input  logic                   out_stall,
	output out_item_t              out_data,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [REGION_BITS-1:0] cfg_data
);

	logic [REGION_BITS-1:0] region_q;

	logic     in_valid_s1;
	in_item_t in_data_s1;

	logic      out_valid_s2;
	out_item_t out_data_s2;

	phase_t                 phase_q;
	logic [4:0]             code_q;
	logic [2:0]             cbl_q;
	logic [COUNT_BITS-1:0]  cv_q;
	logic [COUNT_BITS-1:0]  pbl_q;
	logic [BUDGET_BITS-1:0] cl_q;
	logic                   ctx_q;
	logic                   ws_q;

	phase_t                 ph, ph_n;
	logic [4:0]             code, code_n;
	logic [2:0]             cbl, cbl_n;
	logic [COUNT_BITS-1:0]  cv, cv_n;
	logic [COUNT_BITS-1:0]  pbl, pbl_n;
	logic [BUDGET_BITS-1:0] cl, cl_n;
	logic                   ctx_n;
	logic                   ws, ws_n;
	logic                   exec, ended, code_bad;
	logic [NEED_BITS-1:0]   need;
	logic [BUDGET_BITS+REGION_BITS-1:0] region_wide;
	logic [7:0]             b;
	logic                   res_valid;
	out_item_t              res;
	logic                   s1_go;

	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_s2;
	assign out_data  = out_data_s2;

	assign s1_go    = in_valid_s1 && (!res_valid || !out_valid_s2 || !out_stall);
	assign in_stall = in_valid_s1 && !s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			region_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			in_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall) begin
			in_data_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (s1_go && res_valid) begin
			out_valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && res_valid) begin
			out_data_s2 <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_CMD;
			code_q  <= '0;
			cbl_q   <= '0;
			cv_q    <= '0;
			pbl_q   <= '0;
			cl_q    <= '0;
			ctx_q   <= 1'b0;
			ws_q    <= 1'b0;
		end else if (s1_go) begin
			phase_q <= ph_n;
			code_q  <= code_n;
			cbl_q   <= cbl_n;
			cv_q    <= cv_n;
			pbl_q   <= pbl_n;
			cl_q    <= cl_n;
			ctx_q   <= ctx_n;
			ws_q    <= ws_n;
		end
	end

	always_comb begin
		b = in_data_s1.desc_byte;
		region_wide = {{BUDGET_BITS{1'b0}}, region_q};

		ph   = phase_q;
		code = code_q;
		cbl  = cbl_q;
		cv   = cv_q;
		pbl  = pbl_q;
		cl   = cl_q;
		ws   = ws_q;
		if (in_data_s1.start_of_block) begin
			ph   = PH_CMD;
			code = '0;
			cbl  = '0;
			cv   = '0;
			pbl  = '0;
			cl   = region_wide[BUDGET_BITS-1:0];
			ws   = 1'b0;
		end

		ph_n   = ph;
		code_n = code;
		cbl_n  = cbl;
		cv_n   = cv;
		pbl_n  = pbl;
		cl_n   = cl;
		ctx_n  = ctx_q;
		ws_n   = ws;
		exec   = 1'b0;
		ended  = 1'b0;

		res_valid      = 1'b0;
		res.kind       = K_RAW;
		res.cells      = '0;
		res.cell_count = '0;
		res.weak_cells = '0;
		res.has_weak   = 1'b0;
		res.last       = 1'b0;

		unique case (ph)
			PH_CMD: begin
				code_n = b[4:0];
				cbl_n  = b[7:5];
				cv_n   = '0;
				if (b[7:5] == 3'd0) begin
					exec = 1'b1;
				end else begin
					ph_n = PH_COUNT;
				end
			end
			PH_COUNT: begin
				cv_n  = {cv[COUNT_BITS-9:0], b};
				cbl_n = cbl - 3'd1;
				if (cbl == 3'd1) begin
					exec = 1'b1;
				end
			end
			PH_PAYLOAD: begin
				ctx_n     = b[0];
				res_valid = 1'b1;
				if (code == CODE_RAW) begin
					res.kind       = K_RAW;
					res.cells      = {8'h00, b};
					res.cell_count = CELLS_RAW;
				end else begin
					res.kind       = K_MFM;
					res.cells      = mfm_byte(b, ctx_q);
					res.cell_count = CELLS_MFM;
				end
				pbl_n = pbl - COUNT_BITS'(1);
				if (pbl == COUNT_BITS'(1)) begin
					ph_n = PH_CMD;
				end
			end
			PH_DONE: begin
			end
		endcase

		need = (code_n == CODE_RAW) ? {1'b0, cv_n, 3'b000} : {cv_n, 4'b0000};
		code_bad = !(code_n == CODE_RAW || code_n == CODE_MFM ||
			code_n == CODE_MFM_ALT || code_n == CODE_WEAK);

		if (exec) begin
			priority if (code_n == CODE_END) begin
				ended     = 1'b1;
				ph_n      = PH_DONE;
				res_valid = 1'b1;
				res.kind  = (cl == '0) ? K_OK : K_ERR;
				res.last  = 1'b1;
			end else if (code_bad ||
				need > {{(NEED_BITS-BUDGET_BITS){1'b0}}, cl}) begin
				ended     = 1'b1;
				ph_n      = PH_DONE;
				res_valid = 1'b1;
				res.kind  = K_ERR;
				res.last  = 1'b1;
			end else begin
				cl_n = cl - need[BUDGET_BITS-1:0];
				if (code_n == CODE_WEAK) begin
					ws_n           = 1'b1;
					ctx_n          = 1'b0;
					ph_n           = PH_CMD;
					res_valid      = 1'b1;
					res.kind       = K_WEAK;
					res.weak_cells = need[19:0];
				end else begin
					pbl_n = cv_n;
					ph_n  = (cv_n != '0) ? PH_PAYLOAD : PH_CMD;
				end
			end
		end

		// flag a buffer that ends before the block does
		if (!ended && in_data_s1.end_of_buffer && ph != PH_DONE) begin
			ph_n           = PH_DONE;
			res_valid      = 1'b1;
			res.kind       = K_ERR;
			res.cells      = '0;
			res.cell_count = '0;
			res.weak_cells = '0;
			res.last       = 1'b1;
		end

		res.has_weak = ws_n;
	end

	a_last_ends_block: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && res_valid && res.last) |=> phase_q == PH_DONE)
		else $error("final result did not end the block");

	a_done_is_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && phase_q == PH_DONE && !in_data_s1.start_of_block) |-> !res_valid)
		else $error("result produced after end of block");

	a_weak_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.kind == K_WEAK) |-> out_data.has_weak)
		else $error("weak run without weak flag");

	a_cell_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((out_data.kind == K_RAW && out_data.cell_count == CELLS_RAW) ||
			(out_data.kind == K_MFM && out_data.cell_count == CELLS_MFM) ||
			(out_data.kind != K_RAW && out_data.kind != K_MFM &&
			out_data.cell_count == 5'd0)))
		else $error("cell count does not match kind");

	a_payload_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> pbl_q != '0)
		else $error("payload phase with no bytes left");

endmodule

// ----- tb/tb.sv -----
module tb;
	import csdd_pkg::*;

	localparam int STUCK_LIMIT = 2000;
	localparam int STALL_NONE = 0;
	localparam int STALL_RANDOM = 1;
	localparam int STALL_RUNS = 2;
	localparam logic [4:0] CODE_BAD = 5'd4;
	localparam logic [19:0] REGION_MAX = 20'hfffff;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [REGION_BITS-1:0] cfg_data = '0;

	cell_stream_description_decoder u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// decoder state as predicted
	phase_t ph = PH_CMD;
	logic [4:0] cmd_code = '0;
	logic [2:0] cnt_left = '0;
	logic [31:0] cnt_val = '0;
	logic [31:0] pay_left = '0;
	logic [19:0] budget_left = '0;
	logic ctx = 1'b0;
	logic weak_flag = 1'b0;
	logic [19:0] region_reg = '0;

	in_item_t desc_q[$];
	out_item_t cell_results_q[$];
	out_item_t want;
	int items_sent = 0;
	int fail_count = 0;
	int stuck_cycles = 0;

	bit gaps_on = 1'b0;
	int burst_left = 1;
	int gap_left = 0;
	int stall_mode = STALL_NONE;
	int hold_req = 0;
	int hold_left = 0;
	int run_left = 0;
	bit run_stall = 1'b0;

	function automatic out_item_t make_out(input kind_t k, input logic [15:0] c,
			input logic [4:0] n, input logic [19:0] w, input logic l);
		out_item_t r;
		r.kind = k;
		r.cells = c;
		r.cell_count = n;
		r.weak_cells = w;
		r.has_weak = weak_flag;
		r.last = l;
		return r;
	endfunction

	function automatic bit run_command(output out_item_t r, output bit ended);
		logic [35:0] need;
		r = '0;
		ended = 1'b0;
		if (cmd_code == CODE_END) begin
			ended = 1'b1;
			ph = PH_DONE;
			r = make_out(budget_left == 0 ? K_OK : K_ERR, '0, '0, '0, 1'b1);
			return 1'b1;
		end
		case (cmd_code)
			CODE_RAW: need = {1'b0, cnt_val, 3'b000};
			CODE_MFM, CODE_MFM_ALT, CODE_WEAK: need = {cnt_val, 4'b0000};
			default: need = '1;
		endcase
		if (need > {16'b0, budget_left}) begin
			ended = 1'b1;
			ph = PH_DONE;
			r = make_out(K_ERR, '0, '0, '0, 1'b1);
			return 1'b1;
		end
		budget_left = budget_left - need[19:0];
		if (cmd_code == CODE_WEAK) begin
			weak_flag = 1'b1;
			ctx = 1'b0;
			ph = PH_CMD;
			r = make_out(K_WEAK, '0, '0, need[19:0], 1'b0);
			return 1'b1;
		end
		pay_left = cnt_val;
		ph = (cnt_val != 0) ? PH_PAYLOAD : PH_CMD;
		return 1'b0;
	endfunction

	function automatic void decode_desc_byte(input in_item_t it);
		out_item_t r;
		bit have;
		bit ended;
		logic [7:0] b;
		logic [15:0] mfm;
		b = it.desc_byte;
		have = 1'b0;
		ended = 1'b0;
		r = '0;
		if (it.start_of_block) begin
			ph = PH_CMD;
			cmd_code = '0;
			cnt_left = '0;
			cnt_val = '0;
			pay_left = '0;
			budget_left = region_reg;
			weak_flag = 1'b0;
		end
		if (ph == PH_DONE)
			return;
		case (ph)
			PH_CMD: begin
				cmd_code = b[4:0];
				cnt_left = b[7:5];
				cnt_val = '0;
				if (cnt_left == 0)
					have = run_command(r, ended);
				else
					ph = PH_COUNT;
			end
			PH_COUNT: begin
				cnt_val = {cnt_val[23:0], b};
				cnt_left = cnt_left - 3'd1;
				if (cnt_left == 0)
					have = run_command(r, ended);
			end
			default: begin
				if (cmd_code == CODE_RAW) begin
					ctx = b[0];
					r = make_out(K_RAW, {8'h00, b}, CELLS_RAW, '0, 1'b0);
				end else begin
					mfm = '0;
					for (int i = 7; i >= 0; i--) begin
						mfm = {mfm[13:0], ~(ctx | b[i]), b[i]};
						ctx = b[i];
					end
					r = make_out(K_MFM, mfm, CELLS_MFM, '0, 1'b0);
				end
				have = 1'b1;
				pay_left = pay_left - 1;
				if (pay_left == 0)
					ph = PH_CMD;
			end
		endcase
		if (!ended && it.end_of_buffer) begin
			ph = PH_DONE;
			r = make_out(K_ERR, '0, '0, '0, 1'b1);
			have = 1'b1;
		end
		if (have)
			cell_results_q.push_back(r);
	endfunction

	// sender: hold while stalled, otherwise advance in bursts
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				decode_desc_byte(in_data);
			end
			if (!(in_valid && in_stall)) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (desc_q.size() != 0) begin
					in_valid <= 1'b1;
					in_data <= desc_q.pop_front();
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 16);
						gap_left = gaps_on ? $urandom_range(1, 6) : 0;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (stall_mode == STALL_NONE) begin
			out_stall <= 1'b0;
		end else if (stall_mode == STALL_RANDOM) begin
			out_stall <= ($urandom_range(0, 99) < 35);
		end else begin
			if (run_left == 0) begin
				run_stall = !run_stall;
				run_left = run_stall ? $urandom_range(1, 8) : $urandom_range(1, 12);
			end
			run_left--;
			out_stall <= run_stall;
		end
	end

	function automatic void check_field(input string name, input logic [19:0] exp_v,
			input logic [19:0] got_v);
		if (got_v !== exp_v) begin
			$display("%0t: %s expected %0h actual %0h", $time, name, exp_v, got_v);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (cell_results_q.size() == 0) begin
				$display("%0t: transaction with nothing expected, actual %p", $time, out_data);
				fail_count++;
			end else begin
				want = cell_results_q.pop_front();
				check_field("kind", 20'(want.kind), 20'(out_data.kind));
				check_field("cells", 20'(want.cells), 20'(out_data.cells));
				check_field("cell_count", 20'(want.cell_count), 20'(out_data.cell_count));
				check_field("weak_cells", want.weak_cells, out_data.weak_cells);
				check_field("has_weak", 20'(want.has_weak), 20'(out_data.has_weak));
				check_field("last", 20'(want.last), 20'(out_data.last));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_valid)
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, STUCK_LIMIT);
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic logic [7:0] cmd_byte(input int unsigned nb, input logic [4:0] code);
		return {3'(nb), code};
	endfunction

	function automatic in_item_t desc_item(input logic [7:0] b);
		in_item_t t;
		t = '0;
		t.desc_byte = b;
		return t;
	endfunction

	function automatic void add_run(ref in_item_t blk[$], input logic [4:0] code,
			input int unsigned n);
		int unsigned nb;
		nb = (n == 0) ? 0 : (n < 256) ? 1 : (n < 65536) ? 2 : 3;
		nb = nb + $urandom_range(0, 2);
		if (nb > 7)
			nb = 7;
		blk.push_back(desc_item(cmd_byte(nb, code)));
		for (int i = int'(nb) - 1; i >= 0; i--)
			blk.push_back(desc_item(i < 4 ? 8'(n >> (8 * i)) : 8'h00));
		if (code == CODE_RAW || code == CODE_MFM || code == CODE_MFM_ALT)
			for (int i = 0; i < int'(n); i++)
				blk.push_back(desc_item(8'($urandom)));
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic eob, input logic sob);
		in_item_t t;
		t.desc_byte = b;
		t.end_of_buffer = eob;
		t.start_of_block = sob;
		desc_q.push_back(t);
		items_sent++;
	endtask

	task automatic send_seq(ref in_item_t blk[$]);
		in_item_t t;
		t = blk[0];
		t.start_of_block = 1'b1;
		blk[0] = t;
		foreach (blk[i])
			send_byte(blk[i].desc_byte, blk[i].end_of_buffer, blk[i].start_of_block);
	endtask

	task automatic wait_idle();
		while (desc_q.size() != 0 || in_valid || cell_results_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_region(input logic [19:0] v);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		region_reg = v;
		cfg_valid <= 1'b0;
	endtask

	task automatic send_block(input int unsigned region);
		in_item_t blk[$];
		in_item_t t;
		int unsigned left;
		int unsigned n;
		int unsigned idx;
		logic [4:0] c;
		left = region;
		repeat ($urandom_range(0, 6)) begin
			case ($urandom_range(0, 2))
				0: if (left >= 8) begin
					n = $urandom_range(0, (left / 8 < 4) ? left / 8 : 4);
					add_run(blk, CODE_RAW, n);
					left -= 8 * n;
				end
				1: if (left >= 16) begin
					n = $urandom_range(0, (left / 16 < 4) ? left / 16 : 4);
					add_run(blk, $urandom_range(0, 1) ? CODE_MFM : CODE_MFM_ALT, n);
					left -= 16 * n;
				end
				default: begin
					n = $urandom_range(0, left / 16);
					add_run(blk, CODE_WEAK, n);
					left -= 16 * n;
				end
			endcase
		end
		if (left >= 16) begin
			add_run(blk, CODE_WEAK, left / 16);
			left = left % 16;
		end
		if (left >= 8)
			add_run(blk, CODE_RAW, 1);
		add_run(blk, CODE_END, $urandom_range(0, 1) ? 0 : $urandom_range(0, 255));
		if ($urandom_range(0, 1)) begin
			t = blk[blk.size() - 1];
			t.end_of_buffer = 1'b1;
			blk[blk.size() - 1] = t;
		end
		idx = $urandom_range(0, blk.size() - 1);
		case ($urandom_range(0, 9))
			0: begin
				t = blk[idx];
				t.end_of_buffer = 1'b1;
				blk[idx] = t;
			end
			1: blk.insert(idx + 1, desc_item(8'($urandom)));
			2: if (blk.size() > 1) begin
				void'(blk.pop_back());
			end
			3: begin
				do
					c = 5'($urandom);
				while (c inside {CODE_END, CODE_RAW, CODE_MFM, CODE_MFM_ALT, CODE_WEAK});
				blk.insert(idx + 1, desc_item(cmd_byte($urandom_range(0, 1), c)));
			end
			default: ;
		endcase
		send_seq(blk);
	endtask

	task automatic send_noise();
		repeat ($urandom_range(1, 12))
			send_byte(8'($urandom), $urandom_range(0, 9) == 0, $urandom_range(0, 6) == 0);
	endtask

	task automatic test_before_start();
		send_byte(cmd_byte(0, CODE_END), 1'b0, 1'b0);
		send_byte(cmd_byte(1, CODE_RAW), 1'b0, 1'b0);
		wait_idle();
	endtask

	task automatic test_raw_and_mfm();
		write_region(20'd48);
		send_byte(cmd_byte(1, CODE_RAW), 1'b0, 1'b1);
		send_byte(8'd2, 1'b0, 1'b0);
		send_byte(8'h00, 1'b0, 1'b0);
		send_byte(8'hff, 1'b0, 1'b0);
		send_byte(cmd_byte(1, CODE_MFM), 1'b0, 1'b0);
		send_byte(8'd1, 1'b0, 1'b0);
		send_byte(8'ha5, 1'b0, 1'b0);
		send_byte(cmd_byte(1, CODE_MFM_ALT), 1'b0, 1'b0);
		send_byte(8'd1, 1'b0, 1'b0);
		send_byte(8'h00, 1'b0, 1'b0);
		send_byte(cmd_byte(0, CODE_RAW), 1'b0, 1'b0);
		send_byte(cmd_byte(0, CODE_END), 1'b1, 1'b0);
		wait_idle();
	endtask

	task automatic test_weak_runs();
		send_byte(cmd_byte(1, CODE_WEAK), 1'b0, 1'b1);
		send_byte(8'd2, 1'b0, 1'b0);
		send_byte(cmd_byte(0, CODE_WEAK), 1'b0, 1'b0);
		send_byte(cmd_byte(1, CODE_MFM), 1'b0, 1'b0);
		send_byte(8'd1, 1'b0, 1'b0);
		send_byte(8'h00, 1'b0, 1'b0);
		send_byte(cmd_byte(0, CODE_END), 1'b0, 1'b0);
		wait_idle();
	endtask

	task automatic test_error_cases();
		send_byte(cmd_byte(0, CODE_BAD), 1'b0, 1'b1);
		send_byte(cmd_byte(1, CODE_RAW), 1'b0, 1'b0);
		send_byte(cmd_byte(1, CODE_BAD), 1'b0, 1'b1);
		send_byte(8'h00, 1'b0, 1'b0);
		send_byte(cmd_byte(1, CODE_RAW), 1'b0, 1'b1);
		send_byte(8'hff, 1'b0, 1'b0);
		send_byte(cmd_byte(7, CODE_RAW), 1'b0, 1'b1);
		send_byte(8'h01, 1'b0, 1'b0);
		repeat (6) send_byte(8'h00, 1'b0, 1'b0);
		send_byte(cmd_byte(0, CODE_END), 1'b0, 1'b0);
		send_byte(cmd_byte(1, CODE_RAW), 1'b1, 1'b1);
		wait_idle();
	endtask

	task automatic test_output_holdoff();
		in_item_t blk[$];
		write_region(20'd384);
		gaps_on = 1'b0;
		stall_mode = STALL_NONE;
		add_run(blk, CODE_MFM, 24);
		add_run(blk, CODE_END, 0);
		hold_req = 150;
		send_seq(blk);
		wait_idle();
	endtask

	task automatic test_random_blocks();
		int start_count;
		int phase_no;
		int unsigned region;
		start_count = items_sent;
		phase_no = 0;
		while (items_sent - start_count < 320) begin
			case ($urandom_range(0, 9))
				0: region = 0;
				1: region = REGION_MAX;
				2: region = $urandom_range(0, REGION_MAX);
				default: region = 8 * $urandom_range(1, 60);
			endcase
			if (phase_no == 0)
				region = 0;
			else if (phase_no == 1)
				region = REGION_MAX;
			write_region(20'(region));
			gaps_on = 1'($urandom_range(0, 1));
			stall_mode = $urandom_range(STALL_NONE, STALL_RUNS);
			repeat ($urandom_range(2, 5)) begin
				if ($urandom_range(0, 9) < 8)
					send_block(region);
				else
					send_noise();
			end
			phase_no++;
		end
		wait_idle();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_before_start();
		test_raw_and_mfm();
		test_weak_runs();
		test_error_cases();
		test_output_holdoff();
		test_random_blocks();
		repeat (8) @(posedge clk);
		if (fail_count == 0 && cell_results_q.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
